// ----- hw/rtl/gbat_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the group-by table.
`timescale 1ns / 1ps
package gbat_pkg;

	localparam int MAX_GROUPS = 64;
	localparam int ADDR_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int CNT_W = $clog2(MAX_GROUPS + 1);
	localparam int DATA_W = 32;
	localparam int PADDR_W = 3;

	localparam logic [1:0] ACT_MERGE = 2'd0;
	localparam logic [1:0] ACT_EMIT = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] OP_MIN = 2'd0;
	localparam logic [1:0] OP_MAX = 2'd1;
	localparam logic [1:0] OP_SUM = 2'd2;
	localparam logic [1:0] OP_COUNT = 2'd3;

	localparam logic REG_AGG_OP = 1'b0;
	localparam logic REG_GROUPING = 1'b1;

	localparam logic [1:0] AGG_OP_RESET = OP_SUM;
	localparam logic GROUPING_RESET = 1'b1;

	typedef struct packed {
		logic load;
		logic clr;
		logic rd;
		logic upd;
		logic ins;
		logic drop;
		logic oload;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic full;
		logic cmp_valid;
		logic key_hit;
		logic at_last;
		logic out_busy;
	} dp_stat_t;

endpackage

// ----- hw/rtl/gbat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gbat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/gbat_dp.sv -----
// Datapath: key and aggregate memories, scan pointers, group count and output register.
`timescale 1ns / 1ps
module gbat_dp
	import gbat_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	input  logic [1:0]               agg_op,
	input  logic                     grouping_on,
	input  logic [DATA_W-1:0]        group_key,
	input  logic signed [DATA_W-1:0] agg_value,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [DATA_W-1:0]        out_key,
	output logic signed [DATA_W-1:0] out_aggregate,
	output logic                     last_group,
	output logic                     dropped_flag
);
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  count_q;
	logic              drop_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [ADDR_W-1:0] cp_q;
	logic              cmpv_q;
	logic              ovalid_q;

	logic [DATA_W-1:0] rd_key;
	logic [DATA_W-1:0] rd_agg;
	logic [DATA_W-1:0] upd_agg;
	logic [DATA_W-1:0] wr_agg;
	logic [ADDR_W-1:0] wr_addr;
	logic              wr_en;
	logic              at_last;

	assign wr_en = cmd.upd | cmd.ins;
	assign wr_addr = cmd.upd ? cp_q : count_q[ADDR_W-1:0];

	always_comb begin
		case (agg_op)
			OP_MIN:   upd_agg = ($signed(val_q) < $signed(rd_agg)) ? val_q : rd_agg;
			OP_MAX:   upd_agg = ($signed(rd_agg) < $signed(val_q)) ? val_q : rd_agg;
			OP_SUM:   upd_agg = rd_agg + val_q;
			OP_COUNT: upd_agg = rd_agg + DATA_W'(1);
			default:  upd_agg = rd_agg;
		endcase
	end

	// A new group starts at the item's value, or at one when counting.
	assign wr_agg = cmd.upd ? upd_agg : ((agg_op == OP_COUNT) ? DATA_W'(1) : val_q);

	gbat_ram #(.WIDTH(DATA_W), .DEPTH(MAX_GROUPS)) u_key_ram (
		.clk   (clk),
		.we    (cmd.ins),
		.waddr (wr_addr),
		.wdata (key_q),
		.re    (cmd.rd),
		.raddr (ptr_q[ADDR_W-1:0]),
		.rdata (rd_key)
	);

	gbat_ram #(.WIDTH(DATA_W), .DEPTH(MAX_GROUPS)) u_agg_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_agg),
		.re    (cmd.rd),
		.raddr (ptr_q[ADDR_W-1:0]),
		.rdata (rd_agg)
	);

	assign at_last = (CNT_W'(cp_q) == (count_q - CNT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q <= 1'b0;
			cmpv_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			cmpv_q <= cmd.rd;
			if (cmd.clr) begin
				count_q <= '0;
				drop_q <= 1'b0;
			end else if (cmd.ins) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.drop) begin
				drop_q <= 1'b1;
			end
			if (cmd.oload) begin
				ovalid_q <= 1'b1;
			end else if (!result_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= grouping_on ? group_key : '0;
			val_q <= agg_value;
			ptr_q <= '0;
		end else if (cmd.rd) begin
			ptr_q <= ptr_q + CNT_W'(1);
			cp_q <= ptr_q[ADDR_W-1:0];
		end
		if (cmd.oload) begin
			out_key <= rd_key;
			out_aggregate <= rd_agg;
			last_group <= at_last;
			dropped_flag <= drop_q;
		end
	end

	assign result_valid = ovalid_q;

	assign stat.count_zero = (count_q == '0);
	assign stat.full = (count_q == CNT_W'(MAX_GROUPS));
	assign stat.cmp_valid = cmpv_q;
	assign stat.key_hit = (rd_key == key_q);
	assign stat.at_last = at_last;
	assign stat.out_busy = ovalid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_GROUPS))
		else $error("group count above table size");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins && !cmd.clr |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the group count");

	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> count_q != CNT_W'(MAX_GROUPS))
		else $error("insert into a full table");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |-> count_q == CNT_W'(MAX_GROUPS))
		else $error("merge dropped while table had room");

	a_oload_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.oload |-> !ovalid_q)
		else $error("output register overwritten before it was taken");

endmodule

// ----- hw/rtl/gbat_ctrl.sv -----
// Controller state machine: merge scan, insert, update, emit walk and clear.
`timescale 1ns / 1ps
module gbat_ctrl
	import gbat_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  logic [1:0] action,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_UPD   = 6'b000100,
		S_INS   = 6'b001000,
		S_EWAIT = 6'b010000,
		S_ELOAD = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   accept;

	assign item_stall = (state_q != S_IDLE);
	assign accept = item_valid && (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.load = accept;
				cmd.clr = accept && (action == ACT_CLEAR);
				if (accept && action == ACT_MERGE) begin
					state_nx = S_SCAN;
				end else if (accept && action == ACT_EMIT && !stat.count_zero) begin
					state_nx = S_EWAIT;
				end
			end
			S_SCAN: begin
				// Reads run one entry ahead of the compare.
				if (stat.cmp_valid && stat.key_hit) begin
					state_nx = S_UPD;
				end else if (stat.cmp_valid && stat.at_last) begin
					if (stat.full) begin
						cmd.drop = 1'b1;
						state_nx = S_IDLE;
					end else begin
						state_nx = S_INS;
					end
				end else if (stat.count_zero) begin
					state_nx = S_INS;
				end else begin
					cmd.rd = 1'b1;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_nx = S_IDLE;
			end
			S_INS: begin
				cmd.ins = 1'b1;
				state_nx = S_IDLE;
			end
			S_EWAIT: begin
				if (!stat.out_busy) begin
					cmd.rd = 1'b1;
					state_nx = S_ELOAD;
				end
			end
			S_ELOAD: begin
				cmd.oload = 1'b1;
				state_nx = stat.at_last ? S_IDLE : S_EWAIT;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register lost its one-hot code");

	a_upd_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> $past(state_q) == S_SCAN && $past(stat.key_hit))
		else $error("update entered without a key hit");

	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ELOAD |-> $past(cmd.rd))
		else $error("emit load without a preceding read");

endmodule

// ----- hw/rtl/group_by_aggregate_table_core.sv -----
// Top level of the group-by aggregation table: register port, controller and datapath.
// Merge: a scan of the key memory, one read per cycle, over the groups stored (up to MAX_GROUPS),
// then an update of the hit entry, an insert, or a drop when the table is full; clear is done on acceptance.
// Emit: per group, a memory read, the load of the output register, and the cycle in which
// the result is taken; the walk waits while the result side stalls.
// One item is in work at a time; the next is accepted while the last result still waits.
// Reset empties the table and the drop flag and loads agg_op = sum, grouping on;
// memory contents are not cleared and no entry is read before it is written.
`timescale 1ns / 1ps
module group_by_aggregate_table_core
	import gbat_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [1:0]               action,
	input  logic [DATA_W-1:0]        group_key,
	input  logic signed [DATA_W-1:0] agg_value,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [DATA_W-1:0]        out_key,
	output logic signed [DATA_W-1:0] out_aggregate,
	output logic                     last_group,
	output logic                     dropped_flag
);
	logic [1:0] agg_op_q;
	logic       grouping_on_q;
	logic       reg_wr;
	dp_cmd_t    cmd;
	dp_stat_t   stat;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agg_op_q <= AGG_OP_RESET;
			grouping_on_q <= GROUPING_RESET;
		end else if (reg_wr) begin
			if (paddr[2] == REG_AGG_OP) begin
				agg_op_q <= pwdata[1:0];
			end else begin
				grouping_on_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		case (paddr[2])
			REG_AGG_OP:   prdata = {30'd0, agg_op_q};
			REG_GROUPING: prdata = {31'd0, grouping_on_q};
			default:      prdata = '0;
		endcase
	end

	gbat_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.action     (action),
		.stat       (stat),
		.cmd        (cmd)
	);

	gbat_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.agg_op        (agg_op_q),
		.grouping_on   (grouping_on_q),
		.group_key     (group_key),
		.agg_value     (agg_value),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.out_key       (out_key),
		.out_aggregate (out_aggregate),
		.last_group    (last_group),
		.dropped_flag  (dropped_flag)
	);

endmodule
